@@ design/sts_pkg.sv @@
// Shared types and constants for the source token scanner.
// Used by sts_front, sts_queue, sts_back and source_token_scanner.
package sts_pkg;

    // Longest source accepted; bytes beyond it are dropped
    localparam int MAX_SOURCE_BYTES = 65536;
    localparam int POS_W            = $clog2(MAX_SOURCE_BYTES + 1);

    localparam int TOK_W       = 16;
    localparam int KIND_W      = 5;
    localparam int MAX_TOKENS  = 3;
    localparam int CNT_W       = $clog2(MAX_TOKENS + 1);
    localparam int IDX_W       = $clog2(MAX_TOKENS);

    // Bundle queue depth, a power of two
    localparam int QDEPTH      = 2;
    localparam int QPTR_W      = $clog2(QDEPTH);
    localparam int QCNT_W      = $clog2(QDEPTH + 1);

    // Token kinds
    localparam logic [KIND_W-1:0] KIND_SLASH         = 5'd10;
    localparam logic [KIND_W-1:0] KIND_BANG          = 5'd11;
    localparam logic [KIND_W-1:0] KIND_BANG_EQUAL    = 5'd12;
    localparam logic [KIND_W-1:0] KIND_EQUAL         = 5'd13;
    localparam logic [KIND_W-1:0] KIND_EQUAL_EQUAL   = 5'd14;
    localparam logic [KIND_W-1:0] KIND_LESS          = 5'd15;
    localparam logic [KIND_W-1:0] KIND_LESS_EQUAL    = 5'd16;
    localparam logic [KIND_W-1:0] KIND_GREATER       = 5'd17;
    localparam logic [KIND_W-1:0] KIND_GREATER_EQUAL = 5'd18;
    localparam logic [KIND_W-1:0] KIND_STRING        = 5'd19;
    localparam logic [KIND_W-1:0] KIND_NUMBER        = 5'd20;
    localparam logic [KIND_W-1:0] KIND_IDENT         = 5'd21;
    localparam logic [KIND_W-1:0] KIND_EOF           = 5'd22;
    localparam logic [KIND_W-1:0] KIND_BAD           = 5'd23;
    localparam logic [KIND_W-1:0] KIND_UNTERM        = 5'd24;

    // Scanner modes
    typedef enum logic [3:0] {
        MODE_IDLE,
        MODE_IDENT,
        MODE_NUMBER,
        MODE_STRING,
        MODE_COMMENT,
        MODE_SLASH,
        MODE_OP_BANG,
        MODE_OP_EQUAL,
        MODE_OP_LESS,
        MODE_OP_GREATER
    } t_mode;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [TOK_W-1:0]  start;
        logic [TOK_W-1:0]  length;
        logic [TOK_W-1:0]  line;
    } t_token;

    // All tokens caused by one request
    typedef struct packed {
        logic [CNT_W-1:0]             count;
        t_token [MAX_TOKENS-1:0]      tok;
    } t_bundle;

    typedef struct packed {
        logic    valid;
        t_bundle bundle;
    } t_push;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

    // Clamp an offset or length to the 16-bit output range
    function automatic logic [TOK_W-1:0] sat16(input logic [POS_W-1:0] v);
        logic [31:0] wide;
        wide = 32'(v);
        return (wide > 32'h0000_FFFF) ? {TOK_W{1'b1}} : wide[TOK_W-1:0];
    endfunction

endpackage

@@ design/sts_front.sv @@
// Front end of the source token scanner: holds the scan state, classifies
// each byte and builds the bundle of tokens it causes. Uses sts_pkg.
module sts_front import sts_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic [7:0]    i_byte_value,
    input  logic          i_byte_valid,
    input  logic          i_end_of_source,
    output t_push         o_push
);

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LESS   = 8'h3C;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_GREAT  = 8'h3E;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_Z   = 8'h5A;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_Z   = 8'h7A;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_SOURCE_BYTES);
    localparam logic [TOK_W-1:0] LINE_MAX = {TOK_W{1'b1}};

    t_mode            r_mode, n_mode;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [POS_W-1:0] r_begin, n_begin;
    logic [TOK_W-1:0] r_line, n_line;
    logic             r_halted, n_halted;

    // Kind of the token a pending mode stands for, if any
    function automatic logic [KIND_W:0] pending_kind(input t_mode m);
        logic [KIND_W:0] res;
        res = '0;
        unique case (m)
            MODE_IDENT:      res = {1'b1, KIND_IDENT};
            MODE_NUMBER:     res = {1'b1, KIND_NUMBER};
            MODE_SLASH:      res = {1'b1, KIND_SLASH};
            MODE_OP_BANG:    res = {1'b1, KIND_BANG};
            MODE_OP_EQUAL:   res = {1'b1, KIND_EQUAL};
            MODE_OP_LESS:    res = {1'b1, KIND_LESS};
            MODE_OP_GREATER: res = {1'b1, KIND_GREATER};
            default:         res = '0;
        endcase
        return res;
    endfunction

    // Kind of the two-character form of an operator
    function automatic logic [KIND_W-1:0] op_eq_kind(input t_mode m);
        logic [KIND_W-1:0] res;
        res = KIND_BANG_EQUAL;
        unique case (m)
            MODE_OP_EQUAL:   res = KIND_EQUAL_EQUAL;
            MODE_OP_LESS:    res = KIND_LESS_EQUAL;
            MODE_OP_GREATER: res = KIND_GREATER_EQUAL;
            default:         res = KIND_BANG_EQUAL;
        endcase
        return res;
    endfunction

    // Single-character punctuation: found bit and kind
    function automatic logic [KIND_W:0] punct_kind(input logic [7:0] c);
        logic [KIND_W:0] res;
        res = '0;
        unique case (c)
            CH_LPAREN: res = {1'b1, 5'd0};
            CH_RPAREN: res = {1'b1, 5'd1};
            CH_LBRACE: res = {1'b1, 5'd2};
            CH_RBRACE: res = {1'b1, 5'd3};
            CH_COMMA:  res = {1'b1, 5'd4};
            CH_DOT:    res = {1'b1, 5'd5};
            CH_MINUS:  res = {1'b1, 5'd6};
            CH_PLUS:   res = {1'b1, 5'd7};
            CH_SEMI:   res = {1'b1, 5'd8};
            CH_STAR:   res = {1'b1, 5'd9};
            default:   res = '0;
        endcase
        return res;
    endfunction

    function automatic t_token make_tok(input logic [KIND_W-1:0] kind,
                                        input logic [POS_W-1:0]  start,
                                        input logic [POS_W-1:0]  len,
                                        input logic [TOK_W-1:0]  line);
        t_token t;
        t.kind   = kind;
        t.start  = sat16(start);
        t.length = sat16(len);
        t.line   = line;
        return t;
    endfunction

    // Hold the scan state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_IDLE;
            r_pos    <= '0;
            r_begin  <= '0;
            r_line   <= TOK_W'(1);
            r_halted <= 1'b0;
        end else begin
            r_mode   <= n_mode;
            r_pos    <= n_pos;
            r_begin  <= n_begin;
            r_line   <= n_line;
            r_halted <= n_halted;
        end
    end

    // Scan one request: byte first, then the end mark
    always_comb begin
        t_bundle          bnd;
        logic [CNT_W-1:0] cnt;
        logic             is_alpha, is_digit, is_ws, is_nl, restart;
        logic [KIND_W:0]  pk, pu;

        n_mode   = r_mode;
        n_pos    = r_pos;
        n_begin  = r_begin;
        n_line   = r_line;
        n_halted = r_halted;
        bnd      = '0;
        cnt      = '0;
        restart  = 1'b0;

        is_alpha = (i_byte_value >= CH_LO_A && i_byte_value <= CH_LO_Z) ||
                   (i_byte_value >= CH_UP_A && i_byte_value <= CH_UP_Z) ||
                   (i_byte_value == CH_UNDER);
        is_digit = (i_byte_value >= CH_ZERO && i_byte_value <= CH_NINE);
        is_ws    = (i_byte_value == CH_SPACE) || (i_byte_value == CH_CR) ||
                   (i_byte_value == CH_TAB);
        is_nl    = (i_byte_value == CH_NL);
        pk       = pending_kind(r_mode);
        pu       = punct_kind(i_byte_value);

        if (i_accept && !r_halted) begin
            if (i_byte_valid && r_pos < MAX_POS) begin
                unique case (r_mode)
                    MODE_IDENT:  restart = !(is_alpha || is_digit);
                    MODE_NUMBER: restart = !is_digit;
                    MODE_STRING: begin
                        if (i_byte_value == CH_QUOTE) begin
                            bnd.tok[cnt[IDX_W-1:0]] = make_tok(KIND_STRING, r_begin,
                                r_pos + POS_W'(1) - r_begin, r_line);
                            cnt    = cnt + CNT_W'(1);
                            n_mode = MODE_IDLE;
                        end else if (is_nl && r_line != LINE_MAX) begin
                            n_line = r_line + TOK_W'(1);
                        end
                    end
                    MODE_COMMENT: begin
                        if (is_nl) begin
                            n_mode = MODE_IDLE;
                            if (r_line != LINE_MAX) n_line = r_line + TOK_W'(1);
                        end
                    end
                    MODE_SLASH: begin
                        if (i_byte_value == CH_SLASH) n_mode = MODE_COMMENT;
                        else restart = 1'b1;
                    end
                    MODE_OP_BANG, MODE_OP_EQUAL, MODE_OP_LESS, MODE_OP_GREATER: begin
                        if (i_byte_value == CH_EQUAL) begin
                            bnd.tok[cnt[IDX_W-1:0]] = make_tok(op_eq_kind(r_mode), r_begin,
                                POS_W'(2), r_line);
                            cnt    = cnt + CNT_W'(1);
                            n_mode = MODE_IDLE;
                        end else begin
                            restart = 1'b1;
                        end
                    end
                    default: restart = 1'b1;
                endcase

                if (restart) begin
                    // Flush the pending token, then start on this byte
                    if (pk[KIND_W]) begin
                        bnd.tok[cnt[IDX_W-1:0]] = make_tok(pk[KIND_W-1:0], r_begin,
                            r_pos - r_begin, r_line);
                        cnt = cnt + CNT_W'(1);
                    end
                    n_mode  = MODE_IDLE;
                    n_begin = r_pos;
                    priority if (is_ws) begin
                        n_mode = MODE_IDLE;
                    end else if (is_nl) begin
                        if (r_line != LINE_MAX) n_line = r_line + TOK_W'(1);
                    end else if (i_byte_value == CH_SLASH) begin
                        n_mode = MODE_SLASH;
                    end else if (is_alpha) begin
                        n_mode = MODE_IDENT;
                    end else if (is_digit) begin
                        n_mode = MODE_NUMBER;
                    end else if (i_byte_value == CH_QUOTE) begin
                        n_mode = MODE_STRING;
                    end else if (i_byte_value == CH_BANG) begin
                        n_mode = MODE_OP_BANG;
                    end else if (i_byte_value == CH_EQUAL) begin
                        n_mode = MODE_OP_EQUAL;
                    end else if (i_byte_value == CH_LESS) begin
                        n_mode = MODE_OP_LESS;
                    end else if (i_byte_value == CH_GREAT) begin
                        n_mode = MODE_OP_GREATER;
                    end else if (pu[KIND_W]) begin
                        bnd.tok[cnt[IDX_W-1:0]] = make_tok(pu[KIND_W-1:0], r_pos,
                            POS_W'(1), r_line);
                        cnt = cnt + CNT_W'(1);
                    end else begin
                        bnd.tok[cnt[IDX_W-1:0]] = make_tok(KIND_BAD, r_pos,
                            POS_W'(1), r_line);
                        cnt      = cnt + CNT_W'(1);
                        n_halted = 1'b1;
                    end
                end
                n_pos = r_pos + POS_W'(1);
            end

            // Close the stream on the end mark
            if (!n_halted && i_end_of_source) begin
                n_halted = 1'b1;
                if (n_mode == MODE_STRING) begin
                    bnd.tok[cnt[IDX_W-1:0]] = make_tok(KIND_UNTERM, n_begin,
                        n_pos - n_begin, n_line);
                    cnt = cnt + CNT_W'(1);
                end else begin
                    pk = pending_kind(n_mode);
                    if (pk[KIND_W]) begin
                        bnd.tok[cnt[IDX_W-1:0]] = make_tok(pk[KIND_W-1:0], n_begin,
                            n_pos - n_begin, n_line);
                        cnt = cnt + CNT_W'(1);
                    end
                    bnd.tok[cnt[IDX_W-1:0]] = make_tok(KIND_EOF, n_pos, '0, n_line);
                    cnt    = cnt + CNT_W'(1);
                    n_mode = MODE_IDLE;
                end
            end
        end

        bnd.count       = cnt;
        o_push.bundle   = bnd;
        o_push.valid    = (cnt != '0);
    end

endmodule

@@ design/sts_queue.sv @@
// Short bundle queue between the scanner front and the token back end.
// Uses sts_pkg.
module sts_queue import sts_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_push     i_push,
    input  logic      i_pop,
    output t_bundle   o_head,
    output t_q_status o_status
);

    t_bundle           r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    // Write the pushed bundle
    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr_ptr] <= i_push.bundle;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push.valid) r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            if (i_pop)        r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            unique case ({i_push.valid, i_pop})
                2'b10:   r_count <= r_count + QCNT_W'(1);
                2'b01:   r_count <= r_count - QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_head         = r_mem[r_rd_ptr];
    assign o_status.empty = (r_count == '0);
    assign o_status.full  = (r_count == QCNT_W'(QDEPTH));

endmodule

@@ design/sts_back.sv @@
// Back end of the source token scanner: walks the head bundle one token per
// cycle, while the output is not stalled, into the output register. Uses sts_pkg.
module sts_back import sts_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_bundle   i_head,
    input  t_q_status i_status,
    output logic      o_pop,
    input  logic      i_stall,
    output logic      o_valid,
    output t_token    o_token,
    output logic      o_last
);

    logic [IDX_W-1:0] r_idx, n_idx;
    logic             r_valid;
    t_token           r_token;
    logic             r_last;
    logic             load, is_last;

    // Load when the queue holds a bundle and the output register is free or being taken
    assign load    = !i_status.empty && (!r_valid || !i_stall);
    assign is_last = (CNT_W'(r_idx) + CNT_W'(1) == i_head.count);
    assign o_pop   = load && is_last;
    assign n_idx   = is_last ? '0 : r_idx + IDX_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_idx   <= n_idx;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    // Hold the payload while stalled
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_token <= i_head.tok[r_idx];
            r_last  <= is_last;
        end
    end

    assign o_valid = r_valid;
    assign o_token = r_token;
    assign o_last  = r_last;

endmodule

@@ design/source_token_scanner.sv @@
// Top level of the source token scanner: front scanner, bundle queue and
// token back end. Uses sts_pkg, sts_front, sts_queue and sts_back.

// The scanner takes one source byte per cycle and turns it into tokens with
// kind, start offset, length and line. The tokens a request causes (at most
// three) enter the queue as one bundle, and the output gives them one token
// per cycle while it is not stalled; the two-entry bundle queue between the
// front scanner and the output stage lets further bytes in meanwhile. The
// input stalls only while that queue is full. A token passes through the
// bundle queue and then the output register after its byte is accepted.
// After end of file, a bad character or an unterminated string the block
// takes requests but makes no new tokens until reset.
module source_token_scanner import sts_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [7:0]          i_byte_value,
    input  logic                i_byte_valid,
    input  logic                i_end_of_source,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [KIND_W-1:0]   o_token_kind,
    output logic [TOK_W-1:0]    o_token_start,
    output logic [TOK_W-1:0]    o_token_length,
    output logic [TOK_W-1:0]    o_token_line,
    output logic                o_last_of_run
);

    t_push     push;
    t_bundle   head;
    t_q_status status;
    logic      pop;
    logic      accept;
    t_token    token;

    // Stall the source while the bundle queue is full
    assign o_stall = status.full;
    assign accept  = i_valid && !status.full;

    sts_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_byte_value    (i_byte_value),
        .i_byte_valid    (i_byte_valid),
        .i_end_of_source (i_end_of_source),
        .o_push          (push)
    );

    sts_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_pop    (pop),
        .o_head   (head),
        .o_status (status)
    );

    sts_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head),
        .i_status (status),
        .o_pop    (pop),
        .i_stall  (i_stall),
        .o_valid  (o_valid),
        .o_token  (token),
        .o_last   (o_last_of_run)
    );

    assign o_token_kind   = token.kind;
    assign o_token_start  = token.start;
    assign o_token_length = token.length;
    assign o_token_line   = token.line;

endmodule
